// File: rtl/core/spc_pkg.sv
// Shared constants and controller/datapath handshake types for the stack permutation checker.
`default_nettype none

package spc_pkg;

  localparam int MAX_CARS = 1024;
  localparam int FIELD_W  = 11;
  localparam int DEPTH_W  = $clog2(MAX_CARS + 1);
  localparam int ADDR_W   = $clog2(MAX_CARS);

  typedef struct packed {
    logic load;    // latch the incoming car
    logic push;    // push next_unpushed + 1
    logic pop;     // drop the top, start the read of the entry below
    logic refill;  // move the read data into the top register
    logic finish;  // close out the current car
    logic emit;    // capture the answer into the result register
  } spc_cmd_t;

  typedef struct packed {
    logic push_ok;
    logic top_match;
    logic refill;
    logic last;
  } spc_status_t;

endpackage

`default_nettype wire

// File: rtl/core/spc_channels.sv
// Valid/ready channel interfaces for cars, results and the configuration write.
`default_nettype none

interface spc_car_if;
  import spc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] car;
  modport source (output valid, output car, input ready);
  modport sink (input valid, input car, output ready);
endinterface

interface spc_result_if;
  logic valid;
  logic ready;
  logic achievable;
  modport source (output valid, output achievable, input ready);
  modport sink (input valid, input achievable, output ready);
endinterface

interface spc_cfg_if;
  import spc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] num_cars;
  modport source (output valid, output num_cars, input ready);
  modport sink (input valid, input num_cars, output ready);
endinterface

`default_nettype wire

// File: rtl/core/spc_datapath.sv
// Datapath: siding stack memory, top register, counters and result register.
`default_nettype none

module spc_datapath
  import spc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  spc_cmd_t           cmd,
  output spc_status_t        status,
  input  logic [FIELD_W-1:0] car,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_num_cars,
  output logic               achievable
);

  logic [FIELD_W-1:0] siding_stack [MAX_CARS];
  logic [FIELD_W-1:0] car_q;
  logic [FIELD_W-1:0] num_cars;
  logic [FIELD_W-1:0] next_unpushed;
  logic [FIELD_W-1:0] cars_seen;
  logic [DEPTH_W-1:0] stack_depth;
  logic [FIELD_W-1:0] top;
  logic [FIELD_W-1:0] rd_data;
  logic [FIELD_W-1:0] pushed_car;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;

  assign pushed_car = next_unpushed + FIELD_W'(1);
  assign wr_addr    = stack_depth[ADDR_W-1:0];
  assign rd_addr    = ADDR_W'(stack_depth - DEPTH_W'(2));

  always_comb begin
    status.top_match = (stack_depth != '0) && (top == car_q);
    status.push_ok   = (next_unpushed < num_cars) && (next_unpushed != car_q) &&
                       !status.top_match && (stack_depth < DEPTH_W'(MAX_CARS));
    status.refill    = stack_depth > DEPTH_W'(1);
    status.last      = ({1'b0, cars_seen} + (FIELD_W+1)'(1)) >= {1'b0, num_cars};
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      siding_stack[wr_addr] <= pushed_car;
    end
    if (cmd.pop) begin
      rd_data <= siding_stack[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cars      <= FIELD_W'(1);
      next_unpushed <= '0;
      cars_seen     <= '0;
      stack_depth   <= '0;
    end else begin
      if (cfg_we) begin
        num_cars <= cfg_num_cars;
      end
      if (cmd.push) begin
        next_unpushed <= pushed_car;
        stack_depth   <= stack_depth + DEPTH_W'(1);
      end
      if (cmd.pop) begin
        stack_depth <= stack_depth - DEPTH_W'(1);
      end
      if (cmd.finish) begin
        if (status.last) begin
          next_unpushed <= '0;
          cars_seen     <= '0;
          stack_depth   <= '0;
        end else begin
          cars_seen <= cars_seen + FIELD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      car_q <= car;
    end
    if (cmd.push) begin
      top <= pushed_car;
    end else if (cmd.refill) begin
      top <= rd_data;
    end
    if (cmd.emit) begin
      achievable <= (stack_depth == '0);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/spc_ctrl.sv
// Controller: sequences push, pop and finish steps per car and owns the result valid.
`default_nettype none

module spc_ctrl
  import spc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  spc_status_t status,
  output spc_cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    WORK,
    REFILL,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign in_ready  = (state == IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = WORK;
        end
      end
      WORK: begin
        priority if (status.push_ok) begin
          cmd.push = 1'b1;
        end else if (status.top_match) begin
          cmd.pop    = 1'b1;
          state_next = status.refill ? REFILL : FINISH;
        end else begin
          state_next = FINISH;
        end
      end
      REFILL: begin
        cmd.refill = 1'b1;
        state_next = FINISH;
      end
      FINISH: begin
        if (!status.last) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end else if (slot_free) begin
          // hold the answer until the previous result is taken
          cmd.finish = 1'b1;
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/stack_permutation_checker.sv
// Top level of the stack permutation checker: controller plus datapath.
// Per car: it is latched in IDLE; WORK pushes cars onto the siding until the car is on top, then
// pops it, or goes to FINISH if it can be neither pushed nor popped. A pop that leaves the siding
// non-empty passes through REFILL (registered read of the new top from the stack memory). In
// FINISH the result of a last car is captured, waiting while the previous result is still held.
// A new car is taken only in IDLE, after the last one is through; the push loop sets the pace.
// Reset (rst, synchronous): empties the siding, clears counters, sets num_cars to 1.
`default_nettype none

module stack_permutation_checker
  import spc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  spc_car_if.sink           car_ch,
  spc_result_if.source      result_ch,
  spc_cfg_if.sink           cfg
);

  spc_cmd_t    cmd;
  spc_status_t status;

  assign cfg.ready = 1'b1;

  spc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (car_ch.valid),
    .in_ready  (car_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  spc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .car          (car_ch.car),
    .cfg_we       (cfg.valid),
    .cfg_num_cars (cfg.num_cars),
    .achievable   (result_ch.achievable)
  );

endmodule

`default_nettype wire
